// ===== rtl/fau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fau_pkg: shared types and constants of the fraction arithmetic unit
// Operation codes, status codes, widths and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package fau_pkg;

  localparam int unsigned OpW   = 16;          // operand width
  localparam int unsigned MagW  = 2 * OpW + 1; // magnitude of any product sum
  localparam int unsigned NumW  = 33;
  localparam int unsigned DenW  = 31;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // classified request: either finished early or carries six magnitudes
  typedef struct packed {
    logic            done;   // result already settled by the front
    logic [1:0]      status;
    logic [2:0]      kind;
    logic            p_neg;  // first cross term sign
    logic [OpW:0]    p_x;
    logic [OpW:0]    p_y;
    logic            q_neg;  // second cross term sign
    logic [OpW:0]    q_x;
    logic [OpW:0]    q_y;
    logic            d_neg;  // denominator sign
    logic [OpW:0]    d_x;
    logic [OpW:0]    d_y;
  } req_t;

  typedef struct packed {
    logic [NumW-1:0] res_num;
    logic [DenW-1:0] res_den;
    logic [1:0]      order;
    logic [1:0]      status;
  } res_t;

endpackage

// ===== rtl/fraction_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fraction_arithmetic_unit: rational add, subtract, multiply, divide, compare
// One request in, one reduced fraction out, with gcd reduction.
// ---------------------------------------------------------------------------
// An error or unused kind is answered from the idle state, with no arithmetic.
// Compare, and any zero result, finish after the multiply and sum states. A
// reducing operation runs a binary gcd loop of subtract or shift steps, then
// two 33-bit restoring divisions of one quotient bit per cycle. A two-entry
// queue lets a new request be classified while the engine is busy.
module fraction_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind[2:0]
  input  logic [63:0] in_tdata,   // a_num[15:0], a_den, b_num, b_den
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // res_num[32:0], res_den, order, status, pad
);

  fau_pkg::req_t req_in, req_q;
  fau_pkg::res_t res;
  logic          q_valid, q_ready;

  fau_front u_front (
    .kind (in_tuser),
    .a_num(in_tdata[15:0]),
    .a_den(in_tdata[31:16]),
    .b_num(in_tdata[47:32]),
    .b_den(in_tdata[63:48]),
    .req  (req_in)
  );

  fau_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(req_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(req_q)
  );

  fau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_valid), .req_ready(q_ready), .req(req_q),
    .out_valid(out_tvalid), .out_ready(out_tready), .res(res)
  );

  assign out_tdata = {4'd0, res.status, res.order, res.res_den, res.res_num};

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:66] == fau_pkg::ST_OK |-> out_tdata[63:33] != '0)
    else $error("ok result with zero denominator");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:66] != fau_pkg::ST_OK |-> out_tdata[32:0] == '0)
    else $error("error result with nonzero numerator");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

endmodule

// ===== rtl/fau_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fau_front: request classifier
// Decodes operands into sign and magnitude, catches the error and unused
// cases, and picks the cross terms each operation needs.
// ---------------------------------------------------------------------------
module fau_front (
  input  logic [2:0]                  kind,
  input  logic [fau_pkg::OpW-1:0]     a_num,
  input  logic [fau_pkg::OpW-1:0]     a_den,
  input  logic [fau_pkg::OpW-1:0]     b_num,
  input  logic [fau_pkg::OpW-1:0]     b_den,
  output fau_pkg::req_t               req
);

  logic              an_s, ad_s, bn_s, bd_s;
  logic [fau_pkg::OpW:0] an_m, ad_m, bn_m, bd_m;

  function automatic logic [fau_pkg::OpW:0] mag(input logic [fau_pkg::OpW-1:0] v);
    logic [fau_pkg::OpW:0] e;
    e = {v[fau_pkg::OpW-1], v};
    return v[fau_pkg::OpW-1] ? (~e + 1'b1) : e;
  endfunction

  always_comb begin
    an_s = a_num[fau_pkg::OpW-1];
    ad_s = a_den[fau_pkg::OpW-1];
    bn_s = b_num[fau_pkg::OpW-1];
    bd_s = b_den[fau_pkg::OpW-1];
    an_m = mag(a_num);
    ad_m = mag(a_den);
    bn_m = mag(b_num);
    bd_m = mag(b_den);
    req = '0;
    req.kind = kind;
    priority if (kind > fau_pkg::KIND_CMP) begin
      req.done = 1'b1;
      req.status = fau_pkg::ST_OK;
    end else if (ad_m == '0 || bd_m == '0) begin
      req.done = 1'b1;
      req.status = fau_pkg::ST_ZDEN;
    end else if (kind == fau_pkg::KIND_DIV && bn_m == '0) begin
      req.done = 1'b1;
      req.status = fau_pkg::ST_ZDIV;
    end else if (kind == fau_pkg::KIND_MUL) begin
      req.p_neg = an_s ^ bn_s; req.p_x = an_m; req.p_y = bn_m;
      req.d_neg = ad_s ^ bd_s; req.d_x = ad_m; req.d_y = bd_m;
    end else if (kind == fau_pkg::KIND_DIV) begin
      req.p_neg = an_s ^ bd_s; req.p_x = an_m; req.p_y = bd_m;
      req.d_neg = ad_s ^ bn_s; req.d_x = ad_m; req.d_y = bn_m;
    end else begin
      req.p_neg = an_s ^ bd_s; req.p_x = an_m; req.p_y = bd_m;
      req.q_neg = bn_s ^ ad_s ^ (kind != fau_pkg::KIND_ADD);
      req.q_x = bn_m; req.q_y = ad_m;
      req.d_neg = ad_s ^ bd_s; req.d_x = ad_m; req.d_y = bd_m;
    end
  end

endmodule

// ===== rtl/fau_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fau_queue: two-entry request queue
// Decouples the classifier from the arithmetic engine.
// ---------------------------------------------------------------------------
module fau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  fau_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output fau_pkg::req_t rd_data
);

  fau_pkg::req_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== rtl/fau_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fau_back: arithmetic engine
// Forms the cross products and combines them; a nonzero sum of any kind but compare
// is then reduced by a binary gcd and two restoring divisions, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fau_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  fau_pkg::req_t req,
  output logic          out_valid,
  input  logic          out_ready,
  output fau_pkg::res_t res
);

  localparam int unsigned MW = fau_pkg::MagW;
  localparam int unsigned SW = $clog2(MW + 1);
  localparam int unsigned CW = $clog2(MW);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD, S_GSH, S_DIV, S_DIV2, S_OUT
  } state_t;

  state_t          st_r;
  fau_pkg::req_t   q_r;
  logic [MW-1:0]   p_r, t_r, nm_r, dm_r, u_r, v_r, rem_r, quo_r, g_r;
  logic            nneg_r;
  logic [SW-1:0]   sh_r;
  logic [CW-1:0]   bit_r;
  logic            pass_r;
  logic [MW:0]     trial;
  logic [MW-1:0]   dvd, diff;
  fau_pkg::res_t   res_r;

  assign req_ready = (st_r == S_IDLE) && !out_valid;
  assign res = res_r;
  assign dvd = pass_r ? dm_r : nm_r;
  assign trial = {rem_r, dvd[bit_r]} - {1'b0, g_r};
  assign diff = (u_r > v_r) ? u_r - v_r : v_r - u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (req_valid && req_ready) begin
          q_r <= req;
          if (req.done) begin
            res_r.res_num <= '0;
            res_r.res_den <= (req.status == fau_pkg::ST_OK) ? 31'd1 : 31'd0;
            res_r.order <= fau_pkg::ORD_LT;
            res_r.status <= req.status;
            out_valid <= 1'b1;
          end else st_r <= S_MUL1;
        end
        S_MUL1: begin
          p_r <= MW'(q_r.p_x * q_r.p_y);
          t_r <= MW'(q_r.q_x * q_r.q_y);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          dm_r <= MW'(q_r.d_x * q_r.d_y);
          st_r <= S_SUM;
        end
        S_SUM: begin
          // signed-magnitude add, then push denominator sign onto numerator
          if (q_r.p_neg == q_r.q_neg || t_r == '0) begin
            nm_r <= p_r + t_r; nneg_r <= q_r.p_neg ^ q_r.d_neg;
          end else if (p_r >= t_r) begin
            nm_r <= p_r - t_r; nneg_r <= q_r.p_neg ^ q_r.d_neg;
          end else begin
            nm_r <= t_r - p_r; nneg_r <= q_r.q_neg ^ q_r.d_neg;
          end
          st_r <= S_GCD;
          sh_r <= '0;
        end
        S_GCD: begin
          if (nm_r == '0) begin
            res_r.res_num <= '0;
            res_r.res_den <= 31'd1;
            res_r.order <= (q_r.kind == fau_pkg::KIND_CMP) ? fau_pkg::ORD_EQ
                                                           : fau_pkg::ORD_LT;
            res_r.status <= fau_pkg::ST_OK;
            out_valid <= 1'b1;
            st_r <= S_IDLE;
          end else if (q_r.kind == fau_pkg::KIND_CMP) begin
            res_r.res_num <= '0;
            res_r.res_den <= 31'd1;
            res_r.order <= nneg_r ? fau_pkg::ORD_LT : fau_pkg::ORD_GT;
            res_r.status <= fau_pkg::ST_OK;
            out_valid <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            u_r <= nm_r; v_r <= dm_r;
            st_r <= S_GSH;
          end
        end
        S_GSH: begin
          // binary gcd: strip common twos, then subtract until equal
          if (u_r == v_r) begin
            g_r <= u_r << sh_r;
            rem_r <= '0; quo_r <= '0; pass_r <= 1'b0;
            bit_r <= CW'(MW - 1);
            st_r <= S_DIV;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1; v_r <= v_r >> 1; sh_r <= sh_r + 1'b1;
          end else if (!u_r[0]) u_r <= u_r >> 1;
          else if (!v_r[0]) v_r <= v_r >> 1;
          else if (u_r > v_r) u_r <= diff >> 1;
          else v_r <= diff >> 1;
        end
        S_DIV: begin
          if (!trial[MW]) begin
            rem_r <= trial[MW-1:0];
            quo_r <= {quo_r[MW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[MW-2:0], dvd[bit_r]};
            quo_r <= {quo_r[MW-2:0], 1'b0};
          end
          if (bit_r == '0) st_r <= S_DIV2;
          else bit_r <= bit_r - 1'b1;
        end
        S_DIV2: begin
          if (!pass_r) begin
            nm_r <= quo_r;
            pass_r <= 1'b1; rem_r <= '0; quo_r <= '0;
            bit_r <= CW'(MW - 1);
            st_r <= S_DIV;
          end else st_r <= S_OUT;
        end
        S_OUT: begin
          res_r.res_num <= nneg_r ? ~nm_r[fau_pkg::NumW-1:0] + 1'b1
                                  : nm_r[fau_pkg::NumW-1:0];
          res_r.res_den <= quo_r[fau_pkg::DenW-1:0];
          res_r.order <= fau_pkg::ORD_LT;
          res_r.status <= fau_pkg::ST_OK;
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/fau_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fau_checker: result predictor and scoreboard for the fraction unit
// Watches both stream channels, computes the reduced fraction for every
// accepted request and compares each returned result field by field.
// ---------------------------------------------------------------------------
module fau_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [2:0]  in_tuser,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          errors,
  output int          pending
);

  fau_pkg::res_t fraction_q[$];

  // plain Euclid on magnitudes
  function automatic longint unsigned gcd_u(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fau_pkg::res_t predict_fraction(logic [2:0] k, logic [63:0] d);
    longint an, ad, bn, bd, num, den, g, mag;
    fau_pkg::res_t r;
    an = longint'($signed(d[15:0]));
    ad = longint'($signed(d[31:16]));
    bn = longint'($signed(d[47:32]));
    bd = longint'($signed(d[63:48]));
    r = '0;
    r.res_den = 31'd1;
    if (k > fau_pkg::KIND_CMP) return r;
    if (ad == 0 || bd == 0) begin
      r.res_den = 31'd0;
      r.status = fau_pkg::ST_ZDEN;
      return r;
    end
    if (k == fau_pkg::KIND_DIV && bn == 0) begin
      r.res_den = 31'd0;
      r.status = fau_pkg::ST_ZDIV;
      return r;
    end
    case (k)
      fau_pkg::KIND_MUL: begin num = an * bn; den = ad * bd; end
      fau_pkg::KIND_DIV: begin num = an * bd; den = ad * bn; end
      fau_pkg::KIND_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      default: begin num = an * bd - bn * ad; den = ad * bd; end
    endcase
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (k == fau_pkg::KIND_CMP) begin
      r.order = (num == 0) ? fau_pkg::ORD_EQ
                           : (num < 0 ? fau_pkg::ORD_LT : fau_pkg::ORD_GT);
      return r;
    end
    if (num != 0) begin
      mag = (num < 0) ? -num : num;
      g = longint'(gcd_u(mag, den));
      num = num / g;
      den = den / g;
    end else begin
      den = 1;
    end
    r.res_num = num[fau_pkg::NumW-1:0];
    r.res_den = den[fau_pkg::DenW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fau_pkg::res_t want;
    logic [32:0] got_num;
    logic [30:0] got_den;
    logic [1:0]  got_ord, got_st;
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready)
        fraction_q.push_back(predict_fraction(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got_num = out_tdata[32:0];
        got_den = out_tdata[63:33];
        got_ord = out_tdata[65:64];
        got_st  = out_tdata[67:66];
        if (fraction_q.size() == 0) begin
          $display("%0t: result with no request: %h", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          want = fraction_q.pop_front();
          if (got_num !== want.res_num || got_den !== want.res_den ||
              got_ord !== want.order || got_st !== want.status ||
              out_tdata[71:68] !== 4'd0) begin
            $display("%0t: expected num=%0d den=%0d ord=%0d st=%0d,",
                     $time, $signed(want.res_num), want.res_den, want.order,
                     want.status);
            $display("  got num=%0d den=%0d ord=%0d st=%0d pad=%h",
                     $signed(got_num), got_den, got_ord, got_st, out_tdata[71:68]);
            errors <= errors + 1;
          end
        end
      end
      pending <= fraction_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the fraction arithmetic unit
// Drives directed corner requests, then random ones under varying idling
// on both channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  int          errors;
  int          pending;
  int          send_idle = 30;
  int          recv_idle = 51;

  always #4 clk = ~clk;

  fraction_arithmetic_unit dut (.*);

  fau_checker chk (.*);

  function automatic logic [63:0] pack_req(logic [15:0] an, logic [15:0] ad,
                                           logic [15:0] bn, logic [15:0] bd);
    return {bd, bn, ad, an};
  endfunction

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7));
      1: return -16'($urandom_range(1, 7));
      2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
      3: return 16'($urandom_range(0, 255)) * 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high into the next request when no idle cycle is drawn
  task automatic send(logic [2:0] k, logic [63:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= k;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and hold until every expected result has come back
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // randomly stall the result side
  always @(posedge clk) out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);

  initial begin
    logic [2:0] k;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i <= fau_pkg::KIND_CMP; i++) begin
      k = 3'(i);
      send(k, pack_req(16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
      send(k, pack_req(16'h8000, 16'h8000, 16'h8001, 16'hffff));
      send(k, pack_req(16'd3, 16'd0, 16'd1, 16'd2));
      send(k, pack_req(16'd0, 16'hfffe, 16'd0, 16'd5));
    end
    send(fau_pkg::KIND_CMP, pack_req(16'd1, 16'd2, 16'd2, 16'd4));
    send(fau_pkg::KIND_SUB, pack_req(16'd1, 16'd2, 16'd2, 16'd4));
    send(3'd5, pack_req(16'd1, 16'd2, 16'd3, 16'd4));
    send(3'd7, pack_req(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send(fau_pkg::KIND_ADD, pack_req(16'd6, 16'hfff7, 16'hfffc, 16'd6));
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 30 : (phase == 1) ? 51 : 0;
      recv_idle = (phase == 0) ? 51 : (phase == 1) ? 30 : 0;
      repeat (430) begin
        k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        send(k, pack_req(rand_operand(), rand_operand(), rand_operand(), rand_operand()));
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fau_pkg.sv
rtl/fau_front.sv
rtl/fau_queue.sv
rtl/fau_back.sv
rtl/fraction_arithmetic_unit.sv
bench/fau_checker.sv
bench/tb.sv
